// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files; b64e_queue includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== hw/rtl/b64e_pkg.sv =====
// Package for the Base64 stream encoder: payload types, constants, alphabet lookup.
package b64e_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [6:0] CHAR_PAD     = 7'h3D;  // '='
  localparam logic [6:0] CHAR_PLUS    = 7'h2B;  // '+'
  localparam logic [6:0] CHAR_SLASH   = 7'h2F;  // '/'
  localparam logic [6:0] UPPER_BASE   = 7'h41;  // 'A' - 0
  localparam logic [6:0] LOWER_BASE   = 7'h47;  // 'a' - 26
  localparam logic [6:0] DIGIT_OFFSET = 7'h04;  // 52 - '0'

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } b64e_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } b64e_out_t;

  // One byte's worth of characters, handed from front to back.
  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [1:0]      last_idx;  // index of final character to send
    logic            last;      // final character ends the message
  } b64e_job_t;

  // Queue status seen by front and back.
  typedef struct packed {
    logic full;
    logic not_empty;
  } b64e_qstat_t;

  function automatic logic [6:0] b64_sym(input logic [5:0] idx);
    logic [6:0] code;
    priority if (idx < 6'd26) begin
      code = UPPER_BASE + {1'b0, idx};
    end else if (idx < 6'd52) begin
      code = LOWER_BASE + {1'b0, idx};
    end else if (idx < 6'd62) begin
      code = {1'b0, idx} - DIGIT_OFFSET;
    end else if (idx == 6'd62) begin
      code = CHAR_PLUS;
    end else begin
      code = CHAR_SLASH;
    end
    return code;
  endfunction

endpackage

// ===== hw/rtl/b64e_front.sv =====
// Front end: accepts bytes, tracks group phase, builds the character job.
module b64e_front import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  b64e_in_t    in_payload,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  b64e_qstat_t qstat,
  output logic        push,
  output b64e_job_t   job
);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [5:0] left_r, left_nxt;
  logic       pad_en_r, pad_en_nxt;

  logic [1:0] ph_pre;
  logic [5:0] left_pre;
  logic [6:0] c0;
  logic       grp_done;
  logic [7:0] b;

  assign b         = in_payload.data_byte;
  assign in_stall  = qstat.full;
  assign push      = in_valid && !qstat.full;
  assign cfg_ready = 1'b1;

  always_comb begin
    grp_done = 1'b0;
    unique case (phase_r)
      PH_ONE: begin
        c0       = b64_sym(left_r | {2'b00, b[7:4]});
        left_pre = {b[3:0], 2'b00};
        ph_pre   = PH_TWO;
      end
      PH_TWO: begin
        c0       = b64_sym(left_r | {4'b0000, b[7:6]});
        left_pre = 6'd0;
        ph_pre   = PH_START;
        grp_done = 1'b1;
      end
      default: begin  // start of group; unreachable code 3 behaves the same
        c0       = b64_sym(b[7:2]);
        left_pre = {b[1:0], 4'b0000};
        ph_pre   = PH_ONE;
      end
    endcase

    job.chars[0] = c0;
    job.chars[1] = grp_done ? b64_sym(b[5:0]) : b64_sym(left_pre);
    job.chars[2] = CHAR_PAD;
    job.chars[3] = CHAR_PAD;
    job.last     = in_payload.last_byte;

    priority if (grp_done) begin
      job.last_idx = 2'd1;
    end else if (!in_payload.last_byte) begin
      job.last_idx = 2'd0;
    end else if (pad_en_r) begin
      job.last_idx = (ph_pre == PH_ONE) ? 2'd3 : 2'd2;
    end else begin
      job.last_idx = 2'd1;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    pad_en_nxt = pad_en_r;
    if (push) begin
      phase_nxt = in_payload.last_byte ? PH_START : ph_pre;
      left_nxt  = in_payload.last_byte ? 6'd0 : left_pre;
    end
    if (cfg_valid && cfg_ready) begin
      pad_en_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      left_r   <= 6'd0;
      pad_en_r <= 1'b1;
    end else begin
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      pad_en_r <= pad_en_nxt;
    end
  end

endmodule

// ===== hw/rtl/b64e_queue.sv =====
// Job queue between front and back ends.
`include "assert_macros.svh"

module b64e_queue import b64e_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  b64e_job_t   job_in,
  input  logic        pop,
  output b64e_job_t   head,
  output b64e_qstat_t qstat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  b64e_job_t     mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign head            = mem[rd_ptr_r];
  assign qstat.full      = (cnt_r == CNT_FULL);
  assign qstat.not_empty = (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `ASSERT_NEVER(a_push_full, push && qstat.full, "push into full queue")
  `ASSERT_NEVER(a_pop_empty, pop && !qstat.not_empty, "pop from empty queue")
  `ASSERT_CLK(a_cnt_track, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1), "count lost a push")
  `ASSERT_CLK(a_ptr_gap, (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r), "pointers differ when empty")

endmodule

// ===== hw/rtl/b64e_back.sv =====
// Back end: sends the queued characters one per cycle, unless the output stalls, through the output register.
module b64e_back import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  b64e_qstat_t qstat,
  input  b64e_job_t   head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output b64e_out_t   out_payload
);

  logic       out_valid_r, out_valid_nxt;
  b64e_out_t  out_r;
  logic [1:0] idx_r, idx_nxt;
  logic       advance;
  logic       at_end;

  assign advance     = !out_valid_r || !out_stall;
  assign at_end      = (idx_r == head.last_idx);
  assign pop         = qstat.not_empty && advance && at_end;
  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (advance) begin
      out_valid_nxt = qstat.not_empty;
      if (qstat.not_empty) begin
        idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && qstat.not_empty) begin
      out_r.out_char  <= head.chars[idx_r];
      out_r.last_char <= head.last && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

// ===== hw/rtl/base64_stream_encoder_unit.sv =====
// Top level of the Base64 stream encoder (standard alphabet, optional '=' padding).
//
// Bytes enter on the in_ channel, each with a last-byte flag; Base64 characters
// leave on the out_ channel as 7-bit ASCII, the final one of a message flagged.
// The front end takes one byte per cycle while the job queue has room, turns it
// into a job of one to four characters and pushes it. The back end drains the
// queue head one character per cycle into the output register unless stalled,
// so a byte yields one character (two when it closes a 3-byte group, up to four
// at the end of a message with padding); the single output port thus gives four
// characters per three bytes on long messages. An accepted byte is written into
// the queue, then its first character is taken into the output register. The
// queue holds QUEUE_DEPTH jobs (two or more). pad_enable resets to 1 and is
// written through the cfg_ port, which is always ready; write it only while the
// block is idle. Reset is synchronous; there is no clearing pass.
module base64_stream_encoder_unit import b64e_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  // byte input
  input  logic      in_valid,
  output logic      in_stall,
  input  b64e_in_t  in_payload,
  // character output
  output logic      out_valid,
  input  logic      out_stall,
  output b64e_out_t out_payload,
  // pad_enable register write
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  b64e_qstat_t qstat;   // queue full / not-empty, seen by both ends
  b64e_job_t   job_in;  // job built from the byte in this transfer
  b64e_job_t   head;    // oldest queued job
  logic        push;
  logic        pop;

  // Front: phase and leftover bits, alphabet lookup, flush and pad decision.
  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .qstat      (qstat),
    .push       (push),
    .job        (job_in)
  );

  // Queue: decouples byte intake from character output.
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .job_in (job_in),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  // Back: walks the head job's characters, pops it after the last one.
  b64e_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .qstat       (qstat),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule
